/* design/qsm_pkg.sv */
// Shared types, constants and the sine magnitude function of the QAM symbol modulator.
package qsm_pkg;

   // Defaults for the top-level parameters
   localparam int SINE_TABLE_DEPTH_DEF       = 1024;
   localparam int MAX_SAMPLES_PER_SYMBOL_DEF = 64;
   localparam int PHASE_BITS_DEF             = 32;

   // Field and register widths
   localparam int SYMBOL_WIDTH   = 8;
   localparam int SAMPLE_WIDTH   = 22;
   localparam int ORDER_WIDTH    = 4;
   localparam int SPACING_WIDTH  = 16;
   localparam int STEP_WIDTH     = 32;
   localparam int SPS_WIDTH      = 7;
   localparam int CSR_DATA_WIDTH = 32;

   // Datapath widths
   localparam int LEVEL_WIDTH = 6;   // half-spacing levels, -15 .. 23
   localparam int SINE_WIDTH  = 16;  // signed Q15
   localparam int MAG_WIDTH   = 15;
   localparam int PROD_WIDTH  = 22;
   localparam int SUM_WIDTH   = 23;
   localparam int SPOS_WIDTH  = 6;   // sample number within a symbol
   localparam int MAX_ORDER   = 8;

   // Register reset values
   localparam logic [ORDER_WIDTH-1:0]   ORDER_RESET   = 4'd4;
   localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = 16'd256;
   localparam logic [STEP_WIDTH-1:0]    STEP_RESET    = 32'h1000_0000;
   localparam logic [SPS_WIDTH-1:0]     SPS_RESET     = 7'd8;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SINE_FULL   = 64'd32767;

   typedef enum logic [1:0] {
      CSR_ORDER_LOG2         = 2'd0,
      CSR_SPACING            = 2'd1,
      CSR_PHASE_STEP         = 2'd2,
      CSR_SAMPLES_PER_SYMBOL = 2'd3
   } csr_index_type;

   // Magnitude of sin over the first quadrant; r is the angle as a Q30 fraction
   // of a quarter turn. Taylor series to x^17, every product truncated.
   function automatic logic [MAG_WIDTH-1:0] sine_mag(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
      term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
      term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
      term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
      term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
      term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
      term = ((term * x2) >> 30) / 64'd210; neg = neg + term;
      term = ((term * x2) >> 30) / 64'd272; pos = pos + term;
      s = (pos > neg) ? pos - neg : 64'd0;
      s = (s * SINE_FULL + (64'd1 << 29)) >> 30;
      if (s > SINE_FULL) begin
         s = SINE_FULL;
      end
      return s[MAG_WIDTH-1:0];
   endfunction

endpackage

/* design/qsm_req_if.sv */
// Symbol request channel: valid/ready handshake carrying one data symbol.
interface qsm_req_if;
   import qsm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SYMBOL_WIDTH-1:0] symbol;

   modport source(output valid, output symbol, input ready);
   modport sink(input valid, input symbol, output ready);
endinterface

/* design/qsm_rsp_if.sv */
// Sample response channel: valid/ready handshake carrying one carrier sample.
interface qsm_rsp_if;
   import qsm_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;
   logic                           last_sample;

   modport source(output valid, output sample_value, output last_sample, input ready);
   modport sink(input valid, input sample_value, input last_sample, output ready);
endinterface

/* design/qsm_sine_lookup.sv */
// Registered sine and cosine lookup from a quarter-wave constant table.
module qsm_sine_lookup #(
   parameter int SINE_TABLE_DEPTH = qsm_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     enable,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]      phase_index,
   output logic signed [qsm_pkg::SINE_WIDTH-1:0]    sine_value,
   output logic signed [qsm_pkg::SINE_WIDTH-1:0]    cosine_value
);
   import qsm_pkg::*;

   localparam int IndexBits    = $clog2(SINE_TABLE_DEPTH);
   localparam int QuarterBits  = IndexBits - 2;
   localparam int QuarterDepth = SINE_TABLE_DEPTH / 4;

   // Entry j is sin(j/QuarterDepth of a quarter turn); one extra entry for the peak
   logic [MAG_WIDTH-1:0] quarter_table [QuarterDepth+1];

   for (genvar g = 0; g <= QuarterDepth; g++) begin : g_table
      assign quarter_table[g] = sine_mag(64'(g) << (32 - IndexBits));
   end

   logic [IndexBits-1:0]         lane_index [2];
   logic signed [SINE_WIDTH-1:0] lane_value [2];
   logic signed [SINE_WIDTH-1:0] sine_ff;
   logic signed [SINE_WIDTH-1:0] cosine_ff;

   // Cosine is sine a quarter turn ahead
   assign lane_index[0] = phase_index;
   assign lane_index[1] = phase_index + IndexBits'(QuarterDepth);

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [1:0]             quad;
      logic [QuarterBits-1:0] offset;
      logic [QuarterBits:0]   addr;
      logic [MAG_WIDTH-1:0]   mag;

      always_comb begin
         quad   = lane_index[l][IndexBits-1 -: 2];
         offset = lane_index[l][QuarterBits-1:0];
         // mirror the falling quarters
         if (quad[0]) begin
            addr = (QuarterBits+1)'(QuarterDepth) - {1'b0, offset};
         end else begin
            addr = {1'b0, offset};
         end
         mag = quarter_table[addr];
         if (quad[1]) begin
            lane_value[l] = -$signed({1'b0, mag});
         end else begin
            lane_value[l] = $signed({1'b0, mag});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sine_ff   <= lane_value[0];
         cosine_ff <= lane_value[1];
      end
   end

   assign sine_value   = sine_ff;
   assign cosine_value = cosine_ff;

endmodule

/* design/qam_symbol_modulator.sv */
// QAM symbol modulator: maps a symbol to a grid point and emits its carrier samples.
//
// Usage: each symbol taken on req_if (valid/ready) produces samples_per_symbol
// transactions on rsp_if, each carrying I*sin + Q*cos of the carrier, the last one
// with last_sample set. The symbol keeps its low order_log2 bits; the grid has
// 2^floor(k/2) columns. The carrier phase restarts at zero on every symbol.
// Registers are written through csr_write_en / csr_index / csr_data; the user must
// write them only while the block is idle, which the block does not enforce. An index
// without a register is ignored. The first sample of a symbol is valid on rsp_if after
// it passes the phase index, table lookup, multiply and output registers. Throughput:
// one sample per cycle while rsp_if.ready does not stall the pipeline; the sample
// counter of the generator stage sets how many samples a symbol has (8 after reset).
// The next symbol is taken in the cycle that issues the last sample of the current
// one, so symbols follow each other without a gap. Pipeline: generator, phase index,
// table lookup, multiply, sum/round into the output register.
// When rsp_if.ready is low with a sample waiting, every stage holds.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: order 4, spacing 256, phase step 2^28, 8 samples per symbol.
module qam_symbol_modulator #(
   parameter int SINE_TABLE_DEPTH       = qsm_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int MAX_SAMPLES_PER_SYMBOL = qsm_pkg::MAX_SAMPLES_PER_SYMBOL_DEF,
   parameter int PHASE_BITS             = qsm_pkg::PHASE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   qsm_req_if.sink                               req_if,
   qsm_rsp_if.source                             rsp_if,
   input  logic                                  csr_write_en,
   input  qsm_pkg::csr_index_type                csr_index,
   input  logic [qsm_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import qsm_pkg::*;

   localparam int IndexBits = $clog2(SINE_TABLE_DEPTH);

   // ---------------------------------------------------------------- registers
   logic [ORDER_WIDTH-1:0]   csr_order_ff;
   logic [SPACING_WIDTH-1:0] csr_spacing_ff;
   logic [STEP_WIDTH-1:0]    csr_step_ff;
   logic [SPS_WIDTH-1:0]     csr_sps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_order_ff   <= ORDER_RESET;
         csr_spacing_ff <= SPACING_RESET;
         csr_step_ff    <= STEP_RESET;
         csr_sps_ff     <= SPS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORDER_LOG2:         csr_order_ff   <= csr_data[ORDER_WIDTH-1:0];
            CSR_SPACING:            csr_spacing_ff <= csr_data[SPACING_WIDTH-1:0];
            CSR_PHASE_STEP:         csr_step_ff    <= csr_data[STEP_WIDTH-1:0];
            CSR_SAMPLES_PER_SYMBOL: csr_sps_ff     <= csr_data[SPS_WIDTH-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------- symbol mapping
   logic [ORDER_WIDTH-1:0]        order_k;
   logic [SYMBOL_WIDTH-1:0]       sym_masked;
   logic [2:0]                    col_log;
   logic [3:0]                    cols_m1;
   logic [3:0]                    col_v;
   logic [3:0]                    row_v;
   logic signed [LEVEL_WIDTH-1:0] ih_v;
   logic signed [LEVEL_WIDTH-1:0] qh_v;
   logic [SPS_WIDTH-1:0]          count_v;

   always_comb begin
      order_k = (csr_order_ff > ORDER_WIDTH'(MAX_ORDER)) ? ORDER_WIDTH'(MAX_ORDER)
                                                          : csr_order_ff;
      sym_masked = req_if.symbol & SYMBOL_WIDTH'((9'd1 << order_k) - 9'd1);
      col_log    = order_k[3:1];
      cols_m1    = 4'((5'd1 << col_log) - 5'd1);
      col_v      = sym_masked[3:0] & cols_m1;
      row_v      = 4'(sym_masked >> col_log);
      ih_v       = $signed(LEVEL_WIDTH'({col_v, 1'b0}) - LEVEL_WIDTH'(cols_m1));
      qh_v       = $signed(LEVEL_WIDTH'({row_v, 1'b0}) - LEVEL_WIDTH'(cols_m1));
      priority if (csr_sps_ff == '0) begin
         count_v = SPS_WIDTH'(1);
      end else if (csr_sps_ff > SPS_WIDTH'(MAX_SAMPLES_PER_SYMBOL)) begin
         count_v = SPS_WIDTH'(MAX_SAMPLES_PER_SYMBOL);
      end else begin
         count_v = csr_sps_ff;
      end
   end

   // -------------------------------------------------------- pipeline control
   logic rsp_valid_ff;
   logic stage_en;
   logic req_accept;
   logic gen_last;

   logic                          gen_active_ff;
   logic                          gen_active_in;
   logic [SPOS_WIDTH-1:0]         gen_n_ff;
   logic [SPOS_WIDTH-1:0]         gen_n_in;
   logic [SPS_WIDTH-1:0]          gen_count_ff;
   logic [PHASE_BITS-1:0]         gen_phase_ff;
   logic [PHASE_BITS-1:0]         gen_phase_in;
   logic signed [LEVEL_WIDTH-1:0] gen_ih_ff;
   logic signed [LEVEL_WIDTH-1:0] gen_qh_ff;
   logic                          gen_zero_ff;

   assign stage_en     = !rsp_valid_ff || rsp_if.ready;
   assign gen_last     = (SPS_WIDTH'(gen_n_ff) + SPS_WIDTH'(1)) == gen_count_ff;
   assign req_if.ready = stage_en && (!gen_active_ff || gen_last);
   assign req_accept   = req_if.valid && req_if.ready;

   // ---------------------------------------------------------- generator stage
   always_comb begin
      gen_active_in = gen_active_ff;
      gen_n_in      = gen_n_ff;
      gen_phase_in  = gen_phase_ff;
      if (gen_active_ff && stage_en) begin
         gen_n_in     = gen_n_ff + SPOS_WIDTH'(1);
         gen_phase_in = gen_phase_ff + PHASE_BITS'(csr_step_ff);
         if (gen_last) begin
            gen_active_in = 1'b0;
         end
      end
      // a new symbol restarts the carrier at zero phase
      if (req_accept) begin
         gen_active_in = 1'b1;
         gen_n_in      = '0;
         gen_phase_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
      end else begin
         gen_active_ff <= gen_active_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_n_ff     <= gen_n_in;
      gen_phase_ff <= gen_phase_in;
      if (req_accept) begin
         gen_count_ff <= count_v;
         gen_ih_ff    <= ih_v;
         gen_qh_ff    <= qh_v;
         gen_zero_ff  <= (csr_spacing_ff == '0);
      end
   end

   // ------------------------------------------------- stage 1: phase index
   logic                          s1_valid_ff;
   logic [IndexBits-1:0]          s1_index_ff;
   logic signed [LEVEL_WIDTH-1:0] s1_ih_ff;
   logic signed [LEVEL_WIDTH-1:0] s1_qh_ff;
   logic                          s1_zero_ff;
   logic                          s1_last_ff;

   // ------------------------------------------------- stage 2: sine lookup
   logic                          s2_valid_ff;
   logic signed [LEVEL_WIDTH-1:0] s2_ih_ff;
   logic signed [LEVEL_WIDTH-1:0] s2_qh_ff;
   logic                          s2_zero_ff;
   logic                          s2_last_ff;
   logic signed [SINE_WIDTH-1:0]  s2_sine;
   logic signed [SINE_WIDTH-1:0]  s2_cosine;

   // ------------------------------------------------- stage 3: products
   logic                          s3_valid_ff;
   logic signed [PROD_WIDTH-1:0]  s3_prod_i_ff;
   logic signed [PROD_WIDTH-1:0]  s3_prod_q_ff;
   logic                          s3_zero_ff;
   logic                          s3_last_ff;

   // ------------------------------------------------- stage 4: output
   logic signed [SUM_WIDTH-1:0]    sum_v;
   logic signed [SAMPLE_WIDTH-1:0] rsp_value_ff;
   logic                           rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (stage_en) begin
         s1_valid_ff  <= gen_active_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s1_index_ff <= gen_phase_ff[PHASE_BITS-1 -: IndexBits];
         s1_ih_ff    <= gen_ih_ff;
         s1_qh_ff    <= gen_qh_ff;
         s1_zero_ff  <= gen_zero_ff;
         s1_last_ff  <= gen_last;
      end
   end

   qsm_sine_lookup #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_sine_lookup (
      .clock       (clock),
      .enable      (stage_en),
      .phase_index (s1_index_ff),
      .sine_value  (s2_sine),
      .cosine_value(s2_cosine)
   );

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s2_ih_ff   <= s1_ih_ff;
         s2_qh_ff   <= s1_qh_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_last_ff <= s1_last_ff;

         s3_prod_i_ff <= PROD_WIDTH'(s2_ih_ff) * PROD_WIDTH'(s2_sine);
         s3_prod_q_ff <= PROD_WIDTH'(s2_qh_ff) * PROD_WIDTH'(s2_cosine);
         s3_zero_ff   <= s2_zero_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   // sum is in half spacings: round half up into whole spacings
   assign sum_v = SUM_WIDTH'(s3_prod_i_ff) + SUM_WIDTH'(s3_prod_q_ff) + SUM_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rsp_value_ff <= s3_zero_ff ? '0 : $signed(sum_v[SUM_WIDTH-1:1]);
         rsp_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample_value = rsp_value_ff;
   assign rsp_if.last_sample  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      gen_active_ff |-> (SPS_WIDTH'(gen_n_ff) < gen_count_ff))
      else $error("sample counter ran past the symbol length");

   a_accept_at_boundary: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!gen_active_ff || (gen_last && stage_en)))
      else $error("symbol taken in the middle of another symbol");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (gen_active_ff && gen_n_ff == '0))
      else $error("taken symbol did not start the generator");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (gen_active_ff && stage_en && gen_last && !req_accept) |=> !gen_active_ff)
      else $error("generator kept running after the last sample");

endmodule

/* tb/tb_qam_symbol_modulator.sv */
// Self-checking testbench for qam_symbol_modulator: directed and random symbols against a carrier predictor.
module tb_qam_symbol_modulator;
   timeunit 1ns;
   timeprecision 1ps;
   import qsm_pkg::*;

   localparam int          PIPE_LATENCY    = 4;
   localparam int          SAMPLE_CAP      = 64;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam logic [63:0] QUARTER_TURN    = 64'd1686629713;  // pi/2 in Q30
   localparam logic [63:0] Q30_ONE         = 64'h4000_0000;
   localparam logic [63:0] Q15_FULL        = 64'd32767;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic                           last;
   } carrier_sample_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   csr_index_type             csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   qsm_req_if req();
   qsm_rsp_if rsp();

   qam_symbol_modulator dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req),
      .rsp_if       (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Register copies used for prediction
   logic [ORDER_WIDTH-1:0]   cfg_order;
   logic [SPACING_WIDTH-1:0] cfg_spacing;
   logic [STEP_WIDTH-1:0]    cfg_step;
   logic [SPS_WIDTH-1:0]     cfg_sps;

   carrier_sample_type expected_samples[$];
   int  mismatch_count;
   int  symbols_sent;
   int  samples_checked;
   int  settings_applied;
   int  hold_off_cycles;
   bit  idling_on;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #10_000_000;
      $display("qam_symbol_modulator regression: fail");
      $finish;
   end

   // Sine of a 32-bit turn fraction in Q15: quadrant fold, Taylor series to x^17
   function automatic int carrier_sine(input logic [31:0] angle);
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] rising;
      logic [63:0] falling;
      logic [63:0] mag;
      frac = {34'd0, angle[29:0]};
      if (angle[30]) begin
         frac = Q30_ONE - frac;
      end
      x       = (frac * QUARTER_TURN) >> 30;
      x2      = (x * x) >> 30;
      term    = x;
      rising  = x;
      falling = 64'd0;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            falling = falling + term;
         end else begin
            rising = rising + term;
         end
      end
      mag = (rising > falling) ? rising - falling : 64'd0;
      mag = (mag * Q15_FULL + (64'd1 << 29)) >> 30;
      if (mag > Q15_FULL) begin
         mag = Q15_FULL;
      end
      return angle[31] ? -int'(mag) : int'(mag);
   endfunction

   // Queue every carrier sample that one symbol produces under the current registers
   function automatic void predict_symbol_samples(input logic [SYMBOL_WIDTH-1:0] sym);
      int                 k;
      int                 masked;
      int                 cols;
      int                 i_half;
      int                 q_half;
      int                 count;
      int                 acc;
      logic [31:0]        phase;
      logic [31:0]        angle;
      carrier_sample_type s;
      k      = (cfg_order > 4'd8) ? 8 : int'(cfg_order);
      masked = int'(sym) & ((1 << k) - 1);
      cols   = 1 << (k / 2);
      i_half = 2 * (masked % cols) - (cols - 1);
      q_half = 2 * (masked / cols) - (cols - 1);
      if (cfg_sps == '0) begin
         count = 1;
      end else if (int'(cfg_sps) > SAMPLE_CAP) begin
         count = SAMPLE_CAP;
      end else begin
         count = int'(cfg_sps);
      end
      for (int n = 0; n < count; n++) begin
         phase = 32'(n) * cfg_step;
         angle = {phase[31:22], 22'd0};  // table index back to a turn fraction
         if (cfg_spacing == '0) begin
            s.value = '0;
         end else begin
            acc = i_half * carrier_sine(angle) + q_half * carrier_sine(angle + 32'h4000_0000);
            s.value = SAMPLE_WIDTH'((acc + 1) >>> 1);
         end
         s.last = (n == count - 1);
         expected_samples.push_back(s);
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t ns mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin : sample_checker
      carrier_sample_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d last %0b",
                                      rsp.sample_value, rsp.last_sample));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp.sample_value !== want.value) begin
               report_mismatch($sformatf("sample_value %0d, predicted %0d",
                                         rsp.sample_value, want.value));
            end
            if (rsp.last_sample !== want.last) begin
               report_mismatch($sformatf("last_sample %0b, predicted %0b",
                                         rsp.last_sample, want.last));
            end
         end
      end
   end

   function automatic int idle_gap();
      int roll;
      if (!idling_on) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Sample receiver: random stalls, plus a long hold-off on request
   initial begin : sample_receiver
      int stall;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp.ready <= 1'b0;
            while (hold_off_cycles > 0) begin
               @(posedge clock);
               hold_off_cycles--;
            end
            rsp.ready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 99) < 30) begin
            stall = idle_gap();
            if (stall > 0) begin
               rsp.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Offer one symbol; hold valid across back-to-back transactions
   task automatic offer_symbol(input logic [SYMBOL_WIDTH-1:0] sym);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid  <= 1'b1;
      req.symbol <= sym;
      do @(posedge clock); while (!req.ready);
      predict_symbol_samples(sym);
      symbols_sent++;
   endtask

   task automatic drain_samples();
      req.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] word);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= word;
      @(posedge clock);
   endtask

   // Block must be idle here
   task automatic apply_settings(input logic [31:0] order_word, input logic [31:0] spacing_word,
                                 input logic [31:0] step_word, input logic [31:0] sps_word);
      write_register(CSR_ORDER_LOG2, order_word);
      write_register(CSR_SPACING, spacing_word);
      write_register(CSR_PHASE_STEP, step_word);
      write_register(CSR_SAMPLES_PER_SYMBOL, sps_word);
      csr_write_en <= 1'b0;
      cfg_order   = order_word[ORDER_WIDTH-1:0];
      cfg_spacing = spacing_word[SPACING_WIDTH-1:0];
      cfg_step    = step_word;
      cfg_sps     = sps_word[SPS_WIDTH-1:0];
      settings_applied++;
   endtask

   // Fill the bits above a register's width with noise half of the time
   function automatic logic [31:0] with_upper_noise(input logic [31:0] value, input int width);
      logic [31:0] noise;
      noise = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         noise = '0;
      end
      return (noise << width) | value;
   endfunction

   task automatic test_reset_defaults();
      offer_symbol(8'h00);
      offer_symbol(8'h0F);
      offer_symbol(8'h06);
      offer_symbol(8'hF9);
      drain_samples();
   endtask

   task automatic test_grid_corners();
      apply_settings(32'd8, 32'd65535, 32'h0400_0000, 32'd16);
      offer_symbol(8'h00);
      offer_symbol(8'hFF);
      offer_symbol(8'h0F);
      offer_symbol(8'hF0);
      drain_samples();
      // odd order: grid taller than wide
      apply_settings(32'd7, 32'd1, 32'h8000_0000, 32'd4);
      offer_symbol(8'h7F);
      offer_symbol(8'h80);
      offer_symbol(8'h07);
      drain_samples();
      apply_settings(32'd1, 32'd300, 32'hFFFF_FFFF, 32'd5);
      offer_symbol(8'h00);
      offer_symbol(8'h01);
      drain_samples();
      apply_settings(32'd2, 32'd256, 32'h4000_0000, 32'd4);
      offer_symbol(8'h02);
      offer_symbol(8'h03);
      drain_samples();
   endtask

   task automatic test_special_settings();
      apply_settings(32'd0, 32'd1000, 32'h1000_0000, 32'd3);
      offer_symbol(8'hAA);
      drain_samples();
      apply_settings(32'd15, 32'd777, 32'h1234_5678, 32'd0);
      offer_symbol(8'hFF);
      offer_symbol(8'h5A);
      drain_samples();
      apply_settings(32'd8, 32'd0, 32'h0800_0000, 32'd127);
      offer_symbol(8'hC3);
      drain_samples();
      apply_settings(32'd6, 32'd65535, 32'd0, 32'd64);
      offer_symbol(8'h3F);
      drain_samples();
      apply_settings(32'd9, 32'd12345, 32'h0100_0000, 32'd65);
      offer_symbol(8'h80);
      drain_samples();
   endtask

   // Receiver holds off while symbols keep coming, so the input stalls
   task automatic test_input_backpressure();
      apply_settings(32'd4, 32'd256, $urandom, 32'd3);
      idling_on = 1'b0;
      hold_off_cycles = HOLD_OFF_CYCLES;
      for (int i = 0; i < 40; i++) begin
         offer_symbol(SYMBOL_WIDTH'($urandom));
      end
      drain_samples();
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [31:0] order_word;
      logic [31:0] spacing_word;
      logic [31:0] step_word;
      logic [31:0] sps_word;
      int          roll;
      for (int phase_no = 0; phase_no < 14; phase_no++) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            order_word = $urandom_range(1, 8);
         end else begin
            order_word = (roll < 82) ? 0 : $urandom_range(9, 15);
         end
         roll = $urandom_range(0, 99);
         spacing_word = (roll < 10) ? 0 : (roll < 20) ? 65535 : $urandom_range(1, 65534);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            step_word = '0;
         end else if (roll < 20) begin
            step_word = '1;
         end else if (roll < 35) begin
            step_word = 32'd1 << $urandom_range(20, 31);
         end else begin
            step_word = $urandom;
         end
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            sps_word = $urandom_range(1, 12);
         end else if (roll < 85) begin
            sps_word = $urandom_range(13, 63);
         end else if (roll < 90) begin
            sps_word = 64;
         end else if (roll < 95) begin
            sps_word = 0;
         end else begin
            sps_word = $urandom_range(65, 127);
         end
         apply_settings(with_upper_noise(order_word, ORDER_WIDTH),
                        with_upper_noise(spacing_word, SPACING_WIDTH),
                        step_word,
                        with_upper_noise(sps_word, SPS_WIDTH));
         idling_on = (phase_no != 3);
         for (int i = 0; i < 26; i++) begin
            offer_symbol(SYMBOL_WIDTH'($urandom));
            if ($urandom_range(0, 99) < 4) begin
               drain_samples();
            end
         end
         drain_samples();
      end
      idling_on = 1'b1;
   endtask

   initial begin : run_sequence
      reset        = 1'b1;
      req.valid    = 1'b0;
      req.symbol   = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_ORDER_LOG2;
      csr_data     = '0;
      cfg_order    = 4'd4;
      cfg_spacing  = 16'd256;
      cfg_step     = 32'h1000_0000;
      cfg_sps      = 7'd8;
      idling_on    = 1'b1;
      hold_off_cycles  = 0;
      mismatch_count   = 0;
      symbols_sent     = 0;
      samples_checked  = 0;
      settings_applied = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_grid_corners();
      test_special_settings();
      test_input_backpressure();
      test_random_traffic();

      drain_samples();
      if (expected_samples.size() != 0) begin
         report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
      end
      $display("covered %0d symbols, %0d samples checked, %0d register settings",
               symbols_sent, samples_checked, settings_applied);
      $display("orders 0..15, zero spacing, 0..127 samples per symbol, hold-off and input stall");
      if (mismatch_count == 0) begin
         $display("qam_symbol_modulator regression: pass");
      end else begin
         $display("qam_symbol_modulator regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
design/qsm_pkg.sv
design/qsm_req_if.sv
design/qsm_rsp_if.sv
design/qsm_sine_lookup.sv
design/qam_symbol_modulator.sv
tb/tb_qam_symbol_modulator.sv
